>>> rtl/wmts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmts_pkg
// Shared constants, types and the window weight tables of the segmenter.
// ----------------------------------------------------------------------------
package wmts_pkg;

    localparam int WINDOW_HALF = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int TAPS        = 2 * WINDOW_HALF + 1;
    localparam int TAP_BITS    = $clog2(TAPS + 1);
    localparam int SAMPLE_BITS = 8;
    localparam int ACC_BITS    = WEIGHT_BITS + SAMPLE_BITS + $clog2(TAPS);
    localparam int WSUM_BITS   = WEIGHT_BITS + $clog2(TAPS);
    localparam int THR_BITS    = 14;
    localparam int STEP_BITS   = 16;
    localparam int POS_BITS    = 32;
    localparam int PROD_BITS   = THR_BITS + WSUM_BITS;

    // register indexes of the configuration port
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STEP      = 2'd1;
    localparam logic [1:0] REG_WINDOW    = 2'd2;

    localparam logic [1:0] WIN_RECT = 2'd3;

    localparam logic REPORT_REGION = 1'b0;
    localparam logic REPORT_END    = 1'b1;

    localparam logic [63:0] Q30        = 64'd1073741824;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] HUNDRED_Q30 = 64'd100 * Q30;

    typedef logic [3:0][TAPS-1:0][WEIGHT_BITS-1:0] t_wtab;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic                   clr;
        logic                   tap_v;
        logic [WEIGHT_BITS-1:0] tap_w;
        logic                   mul_en;
    } t_mac_ctl;

    // cos(2*pi*num/TAPS) in Q30, taylor series after range reduction
    function automatic logic signed [63:0] cos_q30(input int unsigned num);
        int unsigned n;
        int unsigned numer;
        logic neg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic signed [63:0] acc;
        n = num % TAPS;
        if (2 * n > TAPS) n = TAPS - n;
        numer = 2 * n;
        neg = 1'b0;
        if (2 * numer > TAPS) begin
            numer = TAPS - numer;
            neg = 1'b1;
        end
        x   = (PI_Q30 * 64'(numer) + 64'(TAPS / 2)) / TAPS;
        x2  = (x * x + (64'd1 << 29)) >> 30;
        mag = Q30;
        acc = $signed(Q30);
        mag = ((mag * x2) >> 30) / 64'd2;   acc = acc - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd12;  acc = acc + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd30;  acc = acc - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd56;  acc = acc + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd90;  acc = acc - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd132; acc = acc + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd182; acc = acc - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd240; acc = acc + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd306; acc = acc - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd380; acc = acc + $signed(mag);
        return neg ? -acc : acc;
    endfunction

    function automatic t_wtab build_weight_rom();
        t_wtab tab;
        int unsigned m;
        logic signed [63:0] c1;
        logic signed [63:0] c2;
        logic signed [63:0] f [4];
        logic [63:0] v;
        logic [63:0] w;
        for (int k = 0; k < TAPS; k++) begin
            m  = (k < WINDOW_HALF) ? WINDOW_HALF - k : k - WINDOW_HALF;
            c1 = cos_q30(m);
            c2 = cos_q30(2 * m);
            f[0] = 64'sd54 * $signed(Q30) + 64'sd46 * c1;
            f[1] = 64'sd50 * $signed(Q30) + 64'sd50 * c1;
            f[2] = 64'sd42 * $signed(Q30) + 64'sd50 * c1 + 64'sd8 * c2;
            f[3] = 64'sd100 * $signed(Q30);
            for (int j = 0; j < 4; j++) begin
                v = (f[j] < 0) ? 64'd0 : $unsigned(f[j]);
                w = ((v << (WEIGHT_BITS - 1)) + 64'd50 * Q30) / HUNDRED_Q30;
                tab[j][k] = w[WEIGHT_BITS-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_wtab WEIGHT_ROM = build_weight_rom();

endpackage
`default_nettype wire

>>> rtl/windowed_mean_threshold_segmenter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_mean_threshold_segmenter
// Windowed weighted mean of a cost stream, thresholded into low regions.
// ----------------------------------------------------------------------------
// Each sample is taken in one transaction and the block stays busy until its
// work is done. For a sample that evaluates a position, the accept and check
// states come first, then one shared multiply-accumulate walks the 33 window
// taps through the single read port of the sample RAM, followed by the drain,
// threshold multiply and region update states and then the finish and done states.
// A sample that evaluates nothing goes from the check state straight to finish
// and done, and positions skipped by decimation go from check straight to region
// update. A sample marked last evaluates all remaining positions (up to 17) and
// sends a report for a region still open, if any, and an end marker. Results leave
// through a pending register and an output register, stalling the sequencer
// only while both are full.
module windowed_mean_threshold_segmenter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_sample,
    input  wire logic        i_last_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_report_kind,
    output logic [31:0]      o_region_start,
    output logic [31:0]      o_region_end,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int TB = wmts_pkg::TAP_BITS;
    localparam int AB = $clog2(wmts_pkg::TAPS);
    localparam int PB = wmts_pkg::POS_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_TAP   = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_FIN1  = 9'b001000000,
        S_FIN2  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [wmts_pkg::THR_BITS-1:0]  r_thr;
    logic [wmts_pkg::STEP_BITS-1:0] r_step;
    logic [1:0]                     r_kind;

    logic [AB-1:0]                  r_wr_ptr, n_wr_ptr;
    logic [PB-1:0]                  r_count, n_count;
    logic [PB-1:0]                  r_evpos, n_evpos;
    logic [wmts_pkg::STEP_BITS-1:0] r_phase, n_phase;
    logic                           r_high, n_high;
    logic [PB-1:0]                  r_lrs, n_lrs;
    logic [PB-1:0]                  r_lastev, n_lastev;
    logic                           r_known, n_known;
    logic [PB-1:0]                  r_newest, n_newest;
    logic                           r_last, n_last;
    logic [PB-1:0]                  r_p, n_p;
    logic [TB-1:0]                  r_k, n_k;

    // pending result, held back until its last-of-run flag is known
    logic                           r_pv, n_pv;
    logic                           r_pkind, n_pkind;
    logic [PB-1:0]                  r_ps, n_ps;
    logic [PB-1:0]                  r_pe, n_pe;

    logic                           r_ov, n_ov;
    logic                           r_okind, n_okind;
    logic [PB-1:0]                  r_os, n_os;
    logic [PB-1:0]                  r_oe, n_oe;
    logic                           r_olast, n_olast;

    logic                     accept;
    logic                     low;
    logic [7:0]               rdata;
    wmts_pkg::t_mac_ctl       mac_ctl;
    logic                     rd_en;
    logic [AB-1:0]            rd_addr;

    logic                     rep_v;
    logic                     rep_kind;
    logic [PB-1:0]            rep_s;
    logic [PB-1:0]            rep_e;
    logic                     stall;

    logic                     lo_skip, hi_skip, far;
    logic [PB-1:0]            tap_pos, tap_dist;
    logic [AB-1:0]            latest;
    logic [AB:0]              addr_wide;
    logic [wmts_pkg::STEP_BITS-1:0] step_eff;
    logic [wmts_pkg::STEP_BITS:0]   phase_inc;
    logic [PB-1:0]            pending;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    wmts_ram #(
        .WIDTH (wmts_pkg::SAMPLE_BITS),
        .DEPTH (wmts_pkg::TAPS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_sample),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    wmts_mac u_mac (
        .i_clk       (i_clk),
        .i_ctl       (mac_ctl),
        .i_rdata     (rdata),
        .i_threshold (r_thr),
        .o_low       (low)
    );

    // tap address generation
    always_comb begin
        lo_skip  = (r_k < TB'(wmts_pkg::WINDOW_HALF)) &&
                   (r_p < PB'(wmts_pkg::WINDOW_HALF) - PB'(r_k));
        tap_pos  = r_p + PB'(r_k) - PB'(wmts_pkg::WINDOW_HALF);
        hi_skip  = (r_k > TB'(wmts_pkg::WINDOW_HALF)) && (tap_pos > r_newest);
        tap_dist = r_newest - tap_pos;
        far      = tap_dist >= PB'(wmts_pkg::TAPS);
        latest   = (r_wr_ptr == '0) ? AB'(wmts_pkg::TAPS - 1) : r_wr_ptr - AB'(1);
        if (latest >= tap_dist[AB-1:0]) begin
            addr_wide = {1'b0, latest} - {1'b0, tap_dist[AB-1:0]};
        end else begin
            addr_wide = {1'b0, latest} + (AB+1)'(wmts_pkg::TAPS) - {1'b0, tap_dist[AB-1:0]};
        end
        rd_addr = addr_wide[AB-1:0];
        rd_en   = (r_state == S_TAP) && !lo_skip && !hi_skip && !far;

        mac_ctl.clr    = (r_state == S_CHECK);
        mac_ctl.tap_v  = rd_en;
        mac_ctl.tap_w  = wmts_pkg::WEIGHT_ROM[r_kind][r_k[AB-1:0]];
        mac_ctl.mul_en = (r_state == S_MUL);
    end

    assign step_eff  = (r_step == '0) ? wmts_pkg::STEP_BITS'(1) : r_step;
    assign phase_inc = {1'b0, r_phase} + (wmts_pkg::STEP_BITS+1)'(1);
    assign pending   = r_newest - r_evpos;

    always_comb begin
        n_state  = r_state;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        n_evpos  = r_evpos;
        n_phase  = r_phase;
        n_high   = r_high;
        n_lrs    = r_lrs;
        n_lastev = r_lastev;
        n_known  = r_known;
        n_newest = r_newest;
        n_last   = r_last;
        n_p      = r_p;
        n_k      = r_k;
        n_pv     = r_pv;
        n_pkind  = r_pkind;
        n_ps     = r_ps;
        n_pe     = r_pe;
        n_ov     = r_ov;
        n_okind  = r_okind;
        n_os     = r_os;
        n_oe     = r_oe;
        n_olast  = r_olast;
        rep_v    = 1'b0;
        rep_kind = wmts_pkg::REPORT_REGION;
        rep_s    = r_lrs;
        rep_e    = r_p;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_newest = r_count;
                    n_count  = r_count + PB'(1);
                    n_wr_ptr = (r_wr_ptr == AB'(wmts_pkg::TAPS - 1)) ? '0 : r_wr_ptr + AB'(1);
                    n_last   = i_last_sample;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (pending >= PB'(wmts_pkg::WINDOW_HALF) || r_last) begin
                    n_p = r_evpos;
                    n_k = '0;
                    if (!r_known || r_phase == '0) begin
                        n_state = S_TAP;
                    end else begin
                        n_state = S_UPD;
                    end
                end else begin
                    n_state = S_FIN1;
                end
            end
            S_TAP: begin
                n_k = r_k + TB'(1);
                if (r_k == TB'(wmts_pkg::TAPS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_known && r_phase == '0 && !low && !r_high) begin
                    rep_v = 1'b1;
                end
            end
            S_FIN1: begin
                if (r_last && r_known && !r_high) begin
                    rep_v = 1'b1;
                    rep_e = r_lastev;
                end
            end
            S_FIN2: begin
                rep_v    = 1'b1;
                rep_kind = wmts_pkg::REPORT_END;
                rep_s    = '0;
                rep_e    = '0;
            end
            S_DONE: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        stall = (rep_v || r_state == S_DONE) && r_pv && r_ov;

        if (!stall) begin
            if (rep_v) begin
                if (r_pv) begin
                    n_ov    = 1'b1;
                    n_okind = r_pkind;
                    n_os    = r_ps;
                    n_oe    = r_pe;
                    n_olast = 1'b0;
                end
                n_pv    = 1'b1;
                n_pkind = rep_kind;
                n_ps    = rep_s;
                n_pe    = rep_e;
            end
            unique case (r_state)
                S_UPD: begin
                    if (!r_known) begin
                        n_high  = !low;
                        n_known = 1'b1;
                    end else if (r_phase == '0) begin
                        if (!low) begin
                            n_high = 1'b1;
                        end else if (r_high) begin
                            n_high = 1'b0;
                            n_lrs  = r_p;
                        end
                        n_lastev = r_p;
                    end
                    n_phase = (phase_inc >= {1'b0, step_eff}) ? '0
                                                              : phase_inc[wmts_pkg::STEP_BITS-1:0];
                    n_evpos = r_evpos + PB'(1);
                    n_state = (r_p == r_newest) ? S_FIN1 : S_CHECK;
                end
                S_FIN1: begin
                    n_state = r_last ? S_FIN2 : S_DONE;
                end
                S_FIN2: begin
                    // stream end: back to the reset state of the stream
                    n_wr_ptr = '0;
                    n_count  = '0;
                    n_evpos  = '0;
                    n_phase  = '0;
                    n_high   = 1'b0;
                    n_lrs    = PB'(1);
                    n_lastev = PB'(1);
                    n_known  = 1'b0;
                    n_state  = S_DONE;
                end
                S_DONE: begin
                    if (r_pv) begin
                        n_ov    = 1'b1;
                        n_okind = r_pkind;
                        n_os    = r_ps;
                        n_oe    = r_pe;
                        n_olast = 1'b1;
                        n_pv    = 1'b0;
                    end
                    n_state = S_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= '0;
            r_step   <= wmts_pkg::STEP_BITS'(1);
            r_kind   <= wmts_pkg::WIN_RECT;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_evpos  <= '0;
            r_phase  <= '0;
            r_high   <= 1'b0;
            r_lrs    <= PB'(1);
            r_lastev <= PB'(1);
            r_known  <= 1'b0;
            r_last   <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_evpos  <= n_evpos;
            r_phase  <= n_phase;
            r_high   <= n_high;
            r_lrs    <= n_lrs;
            r_lastev <= n_lastev;
            r_known  <= n_known;
            r_last   <= n_last;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    wmts_pkg::REG_THRESHOLD: r_thr  <= i_cfg_wdata[wmts_pkg::THR_BITS-1:0];
                    wmts_pkg::REG_STEP:      r_step <= i_cfg_wdata;
                    wmts_pkg::REG_WINDOW:    r_kind <= i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_p      <= n_p;
        r_k      <= n_k;
        r_pkind  <= n_pkind;
        r_ps     <= n_ps;
        r_pe     <= n_pe;
        r_okind  <= n_okind;
        r_os     <= n_os;
        r_oe     <= n_oe;
        r_olast  <= n_olast;
    end

    assign o_out_valid    = r_ov;
    assign o_report_kind  = r_okind;
    assign o_region_start = r_os;
    assign o_region_end   = r_oe;
    assign o_last_of_run  = r_olast;

endmodule
`default_nettype wire

>>> rtl/wmts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/wmts_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmts_mac
// Shared multiply-accumulate over the window taps and threshold compare.
// ----------------------------------------------------------------------------
module wmts_mac (
    input  wire logic                              i_clk,
    input  wire wmts_pkg::t_mac_ctl                i_ctl,
    input  wire logic [wmts_pkg::SAMPLE_BITS-1:0]  i_rdata,
    input  wire logic [wmts_pkg::THR_BITS-1:0]     i_threshold,
    output logic                                   o_low
);

    logic                                 r_rdv;
    logic [wmts_pkg::WEIGHT_BITS-1:0]     r_rdw;
    logic [wmts_pkg::ACC_BITS-1:0]        r_acc;
    logic [wmts_pkg::WSUM_BITS-1:0]       r_wsum;
    logic [wmts_pkg::PROD_BITS-1:0]       r_prod;
    logic [wmts_pkg::WEIGHT_BITS+wmts_pkg::SAMPLE_BITS-1:0] prod_tap;

    assign prod_tap = r_rdw * i_rdata;

    always_ff @(posedge i_clk) begin
        r_rdv <= i_ctl.tap_v;
        r_rdw <= i_ctl.tap_w;
        if (i_ctl.clr) begin
            r_acc  <= '0;
            r_wsum <= '0;
        end else begin
            if (i_ctl.tap_v) begin
                r_wsum <= r_wsum + wmts_pkg::WSUM_BITS'(i_ctl.tap_w);
            end
            // read data arrives in the cycle after its tap
            if (r_rdv) begin
                r_acc <= r_acc + wmts_pkg::ACC_BITS'(prod_tap);
            end
        end
        if (i_ctl.mul_en) begin
            r_prod <= i_threshold * r_wsum;
        end
    end

    assign o_low = ({r_acc, 6'b0} < wmts_pkg::PROD_BITS'(r_prod));

endmodule
`default_nettype wire
